// ===== sv/bslpd_pkg.sv =====
package bslpd_pkg;

	localparam int PIN_W = 8;
	localparam int CFG_W = 8;
	localparam int CFG_IDX_W = 2;
	localparam int OUT_W = 4 * PIN_W;

	localparam logic [CFG_IDX_W-1:0] REG_TICK_INTERVAL    = 2'd0;
	localparam logic [CFG_IDX_W-1:0] REG_LONG_PRESS_COUNT = 2'd1;
	localparam logic [CFG_IDX_W-1:0] REG_PRESSED_LEVEL    = 2'd2;

	localparam logic [7:0] RST_TICK_INTERVAL    = 8'd2;
	localparam logic [7:0] RST_LONG_PRESS_COUNT = 8'd93;
	localparam logic       RST_PRESSED_LEVEL    = 1'b0;

	localparam logic [7:0] HOLD_MAX = 8'hFF;

	typedef struct packed {
		logic [7:0] tick_interval;
		logic [7:0] long_press_count;
		logic       pressed_level;
	} cfg_t;

	typedef struct packed {
		logic short_flag;
		logic long_flag;
		logic short_rise;
		logic long_rise;
	} lane_out_t;

endpackage

// ===== sv/bslpd_lane.sv =====
module bslpd_lane
	import bslpd_pkg::*;
#(
	parameter int SETTLE_SAMPLES = 8
) (
	input  logic      clk,
	input  logic      arst_n,
	input  cfg_t      cfg,
	input  logic      en,
	input  logic      level,
	output lane_out_t lane_out
);

	localparam int SW = (SETTLE_SAMPLES > 1) ? $clog2(SETTLE_SAMPLES) : 1;
	localparam logic [SW-1:0] SETTLE_LAST = SW'(SETTLE_SAMPLES - 1);

	logic [7:0]    tick_q, tick_n;
	logic [SW-1:0] settle_q, settle_n;
	logic [7:0]    hold_q, hold_n, hold_inc;
	logic          short_q, short_n;
	logic          long_q, long_n;
	logic          fire;

	always_comb begin
		fire     = (tick_q == cfg.tick_interval);
		tick_n   = fire ? 8'd0 : tick_q + 8'd1;
		settle_n = settle_q;
		short_n  = short_q;
		long_n   = long_q;
		hold_inc = hold_q;
		if (fire) begin
			if (settle_q == SETTLE_LAST) begin
				settle_n = '0;
				short_n  = 1'b1;
				if (hold_q != HOLD_MAX) begin
					hold_inc = hold_q + 8'd1;
				end
			end else begin
				settle_n = settle_q + SW'(1);
			end
		end
		hold_n = hold_inc;
		// The long test only runs on a fire tick, after the settle update.
		if (fire && short_n && (hold_inc >= cfg.long_press_count)) begin
			long_n = 1'b1;
			hold_n = 8'd0;
		end
		if (level != cfg.pressed_level) begin
			tick_n   = 8'd0;
			settle_n = '0;
			hold_n   = 8'd0;
			short_n  = 1'b0;
			long_n   = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			tick_q   <= 8'd0;
			settle_q <= '0;
			hold_q   <= 8'd0;
			short_q  <= 1'b0;
			long_q   <= 1'b0;
		end else if (en) begin
			tick_q   <= tick_n;
			settle_q <= settle_n;
			hold_q   <= hold_n;
			short_q  <= short_n;
			long_q   <= long_n;
		end
	end

	assign lane_out.short_flag = short_n;
	assign lane_out.long_flag  = long_n;
	assign lane_out.short_rise = short_n & ~short_q;
	assign lane_out.long_rise  = long_n & ~long_q;

endmodule

// ===== sv/button_short_long_press_debounce_unit.sv =====
// Channel  Direction  Word
// s_*      in         tdata[7:0] = pin_levels
// m_*      out        tdata[31:0] = short_held, long_held, short_event, long_event
// cfg_*    in         register write: cfg_we, cfg_index, cfg_data
//
// One word is taken per cycle while s_tready is high; accept registers its result.
// Each lane's counters and flags update at the accepting edge.
// Reset clears every lane and loads the register defaults.
// A stalled result holds the output register; input stays ready while m_tready is high.
module button_short_long_press_debounce_unit
	import bslpd_pkg::*;
#(
	parameter int NUM_BUTTONS    = 8,
	parameter int SETTLE_SAMPLES = 8
) (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 s_tvalid,
	output logic                 s_tready,
	input  logic [PIN_W-1:0]     s_tdata,   // [7:0] pin_levels
	output logic                 m_tvalid,
	input  logic                 m_tready,
	output logic [OUT_W-1:0]     m_tdata,   // [7:0] short_held, [15:8] long_held,
	                                        // [23:16] short_event, [31:24] long_event
	input  logic                 cfg_we,
	input  logic [CFG_IDX_W-1:0] cfg_index,
	input  logic [CFG_W-1:0]     cfg_data
);

	cfg_t             cfg_q;
	logic             accept;
	logic             out_valid_q;
	logic [OUT_W-1:0] out_data_q;
	lane_out_t        lane_res [NUM_BUTTONS];
	logic [PIN_W-1:0] sh, lh, se, le;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.tick_interval    <= RST_TICK_INTERVAL;
			cfg_q.long_press_count <= RST_LONG_PRESS_COUNT;
			cfg_q.pressed_level    <= RST_PRESSED_LEVEL;
		end else if (cfg_we) begin
			case (cfg_index)
				REG_TICK_INTERVAL:    cfg_q.tick_interval    <= cfg_data;
				REG_LONG_PRESS_COUNT: cfg_q.long_press_count <= cfg_data;
				REG_PRESSED_LEVEL:    cfg_q.pressed_level    <= cfg_data[0];
				default: ;
			endcase
		end
	end

	assign s_tready = !out_valid_q || m_tready;
	assign accept   = s_tvalid && s_tready;

	for (genvar b = 0; b < NUM_BUTTONS; b++) begin : g_lane
		logic lvl;
		// Lanes beyond the pin field see a constant low level.
		if (b < PIN_W) begin : g_pin
			assign lvl = s_tdata[b];
		end else begin : g_nopin
			assign lvl = 1'b0;
		end
		bslpd_lane #(
			.SETTLE_SAMPLES(SETTLE_SAMPLES)
		) u_lane (
			.clk     (clk),
			.arst_n  (arst_n),
			.cfg     (cfg_q),
			.en      (accept),
			.level   (lvl),
			.lane_out(lane_res[b])
		);
	end

	for (genvar i = 0; i < PIN_W; i++) begin : g_out
		if (i < NUM_BUTTONS) begin : g_used
			assign sh[i] = lane_res[i].short_flag;
			assign lh[i] = lane_res[i].long_flag;
			assign se[i] = lane_res[i].short_rise;
			assign le[i] = lane_res[i].long_rise;
		end else begin : g_unused
			assign sh[i] = 1'b0;
			assign lh[i] = 1'b0;
			assign se[i] = 1'b0;
			assign le[i] = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (s_tready) begin
			out_valid_q <= s_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (accept) begin
			out_data_q <= {le, se, lh, sh};
		end
	end

	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_data_q;

endmodule
